// ===== hdl/rgb_led_strip_frame_encoder_core_defines.svh =====
// assertion macros shared by the encoder modules
`ifndef RGB_LED_STRIP_FRAME_ENCODER_CORE_DEFINES_SVH
`define RGB_LED_STRIP_FRAME_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGBENC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbenc check failed");

// next-cycle implication, checked outside reset
`define RGBENC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbenc check failed");

`endif

// ===== hdl/rgbenc_pkg.sv =====
// shared types, constants and helpers of the led strip frame encoder
`default_nettype none

package rgbenc_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BRIGHT = 2'd1;
    localparam logic [1:0] CFG_TAIL   = 2'd2;

    // strip modes
    localparam logic [1:0] MODE_NIBBLE  = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd2;

    // tail word limit
    localparam logic [5:0] MAX_TAIL_WORDS = 6'd56;

    // current-controlled level derivation
    localparam logic [12:0] LEV_MULT   = 13'd7967;
    localparam int          DIV_STEPS  = 13;
    localparam logic [4:0]  LEV_RESET  = 5'd31;
    localparam logic [7:0]  BRIGHT_RESET = 8'd255;
    localparam logic [5:0]  TAIL_RESET = 6'd48;

    // word constants
    localparam logic [7:0]  HEAD_FULL  = 8'hFF;
    localparam logic [2:0]  HEAD_CUR   = 3'b111;
    localparam logic [3:0]  NIB_ONE    = 4'hE;
    localparam logic [3:0]  NIB_ZERO   = 4'h8;

    // input item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       first_pixel;
        logic       last_pixel;
    } t_pixel;

    // result item
    typedef struct packed {
        logic [31:0] out_word;
        logic        last_word;
    } t_result;

    // live configuration seen by the front
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] bright;
        logic [4:0] lev;
        logic [7:0] cur_inten;
        logic [5:0] tail;
        logic       busy;
    } t_cfg;

    // classified pixel command queued for the back
    typedef struct packed {
        logic       nibble_mode;
        logic       start;
        logic [5:0] tail_cnt;
        logic [7:0] head;
        logic [7:0] sr;
        logic [7:0] sg;
        logic [7:0] sb;
    } t_cmd;

    // word sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SW_G,
        ST_SW_R,
        ST_SW_B,
        ST_PIX,
        ST_TAIL
    } t_back_state;

    // one nibble per data bit, msb first
    function automatic logic [31:0] nibble_code(input logic [7:0] byte_in);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            w[4*k +: 4] = byte_in[k] ? NIB_ONE : NIB_ZERO;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_led_strip_frame_encoder_core.sv =====
// Pixel to SPI word encoder for addressable RGB LED strips.
// Input channel (i_in_valid/o_in_ready) takes one pixel per transfer; output
// channel (o_out_valid/i_out_ready) gives one 32-bit word per transfer,
// last_word marking the final word of each pixel.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
// (0 mode, 1 brightness, 2 tail words); index 3 is ignored.
// Throughput: one word per cycle while the queue holds commands and the
// receiver takes words. Single-wire mode gives three words per pixel; clocked
// modes one word per pixel, plus a start word and one per tail word. The output word sequencer sets this figure.
// A pixel transferred into an idle block passes the command queue, the sequencer
// state register and the output register before o_out_valid rises.
// A brightness write starts a 13-step divider for the current-controlled
// level; o_in_ready is low while it runs.
// Reset clears the queue and sequencer and loads mode 0, brightness 255 and
// 48 tail words. A stalled receiver holds the output word; the command queue
// keeps taking pixels until it is full, then o_in_ready drops.
`default_nettype none

module rgb_led_strip_frame_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire rgbenc_pkg::t_pixel  i_pixel,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rgbenc_pkg::t_result      o_result
);
    import rgbenc_pkg::*;

    t_cfg s_cfg;
    t_cmd s_push_cmd;
    t_cmd s_head_cmd;
    logic s_push;
    logic s_pop;
    logic s_full;
    logic s_empty;

    // configuration and level divider
    rgbenc_lvl u_lvl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    // pixel classification
    rgbenc_front u_front (
        .i_pixel    (i_pixel),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg      (s_cfg),
        .i_full     (s_full),
        .o_push     (s_push),
        .o_cmd      (s_push_cmd)
    );

    // command queue
    rgbenc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_push_cmd),
        .i_pop   (s_pop),
        .o_cmd   (s_head_cmd),
        .o_full  (s_full),
        .o_empty (s_empty)
    );

    // word sequencer
    rgbenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_head_cmd),
        .i_empty     (s_empty),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== hdl/rgbenc_lvl.sv =====
// configuration registers and the current-controlled intensity divider
`default_nettype none

module rgbenc_lvl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [7:0]       i_cfg_data,
    output rgbenc_pkg::t_cfg      o_cfg
);
    import rgbenc_pkg::*;

    logic [1:0]  r_mode;
    logic [7:0]  r_bright;
    logic [5:0]  r_tail;
    logic [4:0]  r_lev;
    logic [4:0]  r_rem;
    logic [12:0] r_quo;
    logic [3:0]  r_cnt;

    logic [20:0] s_lev_prod;
    logic [4:0]  s_lev;
    logic [12:0] s_dividend;
    logic [5:0]  s_trial;
    logic        s_ge;
    logic        s_bright_we;

    // level and dividend from the written brightness
    assign s_lev_prod  = 21'(i_cfg_data) * 21'(LEV_MULT);
    assign s_lev       = s_lev_prod[20:16] + 5'd1;
    assign s_dividend  = 13'({i_cfg_data, 5'b0}) - 13'(i_cfg_data);
    assign s_bright_we = i_cfg_we && (i_cfg_idx == CFG_BRIGHT);

    // one restoring division step
    assign s_trial = {r_rem, r_quo[12]};
    assign s_ge    = s_trial >= {1'b0, r_lev};

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NIBBLE;
            r_bright <= BRIGHT_RESET;
            r_tail   <= TAIL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_BRIGHT: r_bright <= i_cfg_data;
                CFG_TAIL:   r_tail   <= i_cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    // divider: i*31 / lev, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lev <= LEV_RESET;
            r_quo <= 13'(BRIGHT_RESET);
            r_rem <= '0;
        end else if (s_bright_we) begin
            r_cnt <= 4'(DIV_STEPS);
            r_lev <= s_lev;
            r_quo <= s_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
            r_quo <= {r_quo[11:0], s_ge};
            r_rem <= s_ge ? 5'(s_trial - {1'b0, r_lev}) : s_trial[4:0];
        end
    end

    // live configuration, saturated where needed
    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.bright    = r_bright;
        o_cfg.lev       = r_lev;
        o_cfg.cur_inten = (r_quo[12:8] != '0) ? 8'hFF : r_quo[7:0];
        o_cfg.tail      = (r_tail > MAX_TAIL_WORDS) ? MAX_TAIL_WORDS : r_tail;
        o_cfg.busy      = r_cnt != '0;
    end

endmodule

`default_nettype wire

// ===== hdl/rgbenc_front.sv =====
// front: accepts pixels, scales colours and classifies them into commands
`default_nettype none

module rgbenc_front (
    input  wire rgbenc_pkg::t_pixel i_pixel,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rgbenc_pkg::t_cfg   i_cfg,
    input  wire logic               i_full,
    output logic                    o_push,
    output rgbenc_pkg::t_cmd        o_cmd
);
    import rgbenc_pkg::*;

    logic        s_cur;
    logic [7:0]  s_inten;
    logic [8:0]  s_mult;
    logic [16:0] s_pr;
    logic [16:0] s_pg;
    logic [16:0] s_pb;

    // accept while the queue has room and the level is settled
    assign o_in_ready = !i_full && !i_cfg.busy;
    assign o_push     = i_in_valid && o_in_ready;

    // effective intensity
    assign s_cur   = i_cfg.mode == MODE_CURRENT;
    assign s_inten = s_cur ? i_cfg.cur_inten : i_cfg.bright;
    assign s_mult  = {1'b0, s_inten} + 9'd1;

    // c*(1+i)>>8 per channel
    assign s_pr = 17'(i_pixel.red)   * 17'(s_mult);
    assign s_pg = 17'(i_pixel.green) * 17'(s_mult);
    assign s_pb = 17'(i_pixel.blue)  * 17'(s_mult);

    // command fields
    always_comb begin
        o_cmd.nibble_mode = i_cfg.mode == MODE_NIBBLE;
        o_cmd.start       = i_pixel.first_pixel && (i_cfg.mode != MODE_NIBBLE);
        o_cmd.tail_cnt    = i_pixel.last_pixel ? i_cfg.tail : 6'd0;
        o_cmd.head        = s_cur ? {HEAD_CUR, i_cfg.lev} : HEAD_FULL;
        o_cmd.sr          = s_pr[15:8];
        o_cmd.sg          = s_pg[15:8];
        o_cmd.sb          = s_pb[15:8];
    end

endmodule

`default_nettype wire

// ===== hdl/rgbenc_fifo.sv =====
// command queue between front and back
`default_nettype none
`include "rgb_led_strip_frame_encoder_core_defines.svh"

module rgbenc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rgbenc_pkg::t_cmd i_cmd,
    input  wire logic             i_pop,
    output rgbenc_pkg::t_cmd      o_cmd,
    output logic                  o_full,
    output logic                  o_empty
);
    import rgbenc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `RGBENC_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `RGBENC_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

// ===== hdl/rgbenc_back.sv =====
// back: expands queued commands into spi words behind an output register
`default_nettype none
`include "rgb_led_strip_frame_encoder_core_defines.svh"

module rgbenc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rgbenc_pkg::t_cmd   i_cmd,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rgbenc_pkg::t_result     o_result
);
    import rgbenc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_back_state s_entry;
    t_cmd        r_cmd;
    logic [5:0]  r_tail_left;
    logic [5:0]  n_tail_left;
    logic        r_out_valid;
    t_result     r_out;

    logic        s_out_free;
    logic        s_adv;
    logic        s_final;
    logic [31:0] s_word;

    // output register frees when empty or taken
    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_adv      = (r_state != ST_IDLE) && s_out_free;
    assign o_pop      = !i_empty && ((r_state == ST_IDLE) || (s_adv && s_final));

    // first state of the queue head
    always_comb begin
        if (i_cmd.nibble_mode) begin
            s_entry = ST_SW_G;
        end else if (i_cmd.start) begin
            s_entry = ST_START;
        end else begin
            s_entry = ST_PIX;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_tail_left = r_tail_left;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) n_state = s_entry;
            end
            ST_START: begin
                if (s_adv) n_state = ST_PIX;
            end
            ST_SW_G: begin
                if (s_adv) n_state = ST_SW_R;
            end
            ST_SW_R: begin
                if (s_adv) n_state = ST_SW_B;
            end
            ST_SW_B, ST_PIX: begin
                if (s_adv) begin
                    if (r_cmd.tail_cnt != '0) begin
                        n_state     = ST_TAIL;
                        n_tail_left = r_cmd.tail_cnt;
                    end else begin
                        n_state = i_empty ? ST_IDLE : s_entry;
                    end
                end
            end
            ST_TAIL: begin
                if (s_adv) begin
                    if (r_tail_left == 6'd1) begin
                        n_state = i_empty ? ST_IDLE : s_entry;
                    end else begin
                        n_tail_left = r_tail_left - 6'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // word of the current state
    always_comb begin
        s_word  = '0;
        s_final = 1'b0;
        case (r_state)
            ST_SW_G: s_word = nibble_code(r_cmd.sg);
            ST_SW_R: s_word = nibble_code(r_cmd.sr);
            ST_SW_B: begin
                s_word  = nibble_code(r_cmd.sb);
                s_final = r_cmd.tail_cnt == '0;
            end
            ST_PIX: begin
                s_word  = {r_cmd.head, r_cmd.sb, r_cmd.sg, r_cmd.sr};
                s_final = r_cmd.tail_cnt == '0;
            end
            ST_TAIL: s_final = r_tail_left == 6'd1;
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tail_left <= '0;
        end else begin
            r_state     <= n_state;
            r_tail_left <= n_tail_left;
        end
    end

    // current command
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out.out_word  <= s_word;
            r_out.last_word <= s_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `RGBENC_ASSERT_NOW(a_tail_count_live, i_clk, i_rst_n, r_state == ST_TAIL, r_tail_left != '0)
    `RGBENC_ASSERT_NEXT(a_word_loaded, i_clk, i_rst_n, s_adv, r_out_valid)

endmodule

`default_nettype wire

// ===== sim/rgb_led_strip_frame_encoder_core_tb.sv =====
// testbench of the led strip frame encoder: directed table, then randomized pixel traffic
module rgb_led_strip_frame_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbenc_pkg::*;

    // modes not named in the package
    localparam logic [1:0] MODE_CLOCKED = 2'd1;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic [31:0] NIB_ALL0 = 32'h8888_8888;
    localparam logic [31:0] NIB_ALL1 = 32'hEEEE_EEEE;
    localparam logic [31:0] Z32      = 32'h0000_0000;
    localparam t_pixel      PX_NONE  = '0;

    localparam int TAIL_CAP    = 56;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_BLOCKS = 8;
    localparam int BLOCK_ITEMS = 40;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_kind;

    // one directed step: a register write or a pixel, optionally with typed words
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [7:0]  data;
        t_pixel      px;
        logic [1:0]  n_typed;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } t_dir_row;

    // pixel literal is {red, green, blue, first, last}
    localparam t_dir_row DIR_TBL [0:34] = '{
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h00, 8'h00, 8'h00, 2'b00}, 2'd3,
          NIB_ALL0, NIB_ALL0, NIB_ALL0},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'h00, 8'hFF, 2'b00}, 2'd3,
          NIB_ALL0, NIB_ALL1, NIB_ALL1},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hA5, 8'h5A, 8'h3C, 2'b00}, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b11}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_TAIL, 8'hFF, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h55, 8'hAA, 8'h0F, 2'b01}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'h00, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b00}, 2'd3,
          NIB_ALL0, NIB_ALL0, NIB_ALL0},
        '{ROW_CFG, CFG_BRIGHT, 8'h80, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h80, 8'h7F, 8'h01, 2'b10}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_TAIL, 8'h00, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hC3, 8'h3C, 8'h81, 2'b01}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_MODE, {6'd0, MODE_CLOCKED}, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'hFF, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'h00, 8'h80, 2'b10}, 2'd2,
          Z32, 32'hFF80_00FF, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h12, 8'h34, 8'h56, 2'b00}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_TAIL, 8'd56, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b11}, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h00, 8'h00, 8'h00, 2'b01}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_MODE, {6'd0, MODE_CURRENT}, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'h00, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b10}, 2'd2,
          Z32, 32'hE100_0000, Z32},
        '{ROW_CFG, CFG_TAIL, 8'd3, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'hFF, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'h80, 8'h01, 2'b11}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'h01, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b00}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'hC8, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h7E, 8'hE7, 8'h99, 2'b10}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_MODE, {6'd0, MODE_SPARE}, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_BRIGHT, 8'h4D, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'h00, 8'hFF, 2'b10}, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'h01, 8'hFE, 8'h80, 2'b01}, 2'd0, Z32, Z32, Z32},
        '{ROW_CFG, CFG_MODE, {6'd0, MODE_NIBBLE}, PX_NONE, 2'd0, Z32, Z32, Z32},
        '{ROW_PIX, CFG_MODE, 8'h00, {8'hFF, 8'hFF, 8'hFF, 2'b01}, 2'd0, Z32, Z32, Z32}
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_MODE;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       i_out_ready = 1'b0;
    t_pixel     i_pixel    = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_result    o_result;

    // shadow of the block's registers, as last written
    logic [1:0] mode_reg   = MODE_NIBBLE;
    logic [7:0] bright_reg = 8'hFF;
    logic [5:0] tail_reg   = 6'd48;

    t_result pending_words[$];
    int      word_errors   = 0;
    int      quiet_cycles  = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic    hold_req      = 1'b0;
    logic    hold_done     = 1'b0;

    rgb_led_strip_frame_encoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always #1 i_clk = ~i_clk;

    // colour scaled by global intensity
    function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] inten);
        logic [15:0] prod;
        prod = c * ({1'b0, inten} + 9'd1);
        return prod[15:8];
    endfunction

    // each data bit, msb first, widened to a 4-bit line code
    function automatic logic [31:0] nibble_spread(input logic [7:0] val);
        logic [31:0] w;
        w = '0;
        for (int b = 7; b >= 0; b--) begin
            w = {w[27:0], val[b] ? 4'hE : 4'h8};
        end
        return w;
    endfunction

    // queue up the words one pixel must produce under the current registers
    function automatic void encode_pixel_words(input t_pixel px);
        logic [7:0]  inten;
        logic [7:0]  head;
        logic [20:0] lev_prod;
        logic [4:0]  lev;
        logic [12:0] rescaled;
        logic [31:0] words[$];
        int          tails;
        inten = bright_reg;
        head  = 8'hFF;
        if (mode_reg == MODE_NIBBLE) begin
            words.push_back(nibble_spread(scale_level(px.green, inten)));
            words.push_back(nibble_spread(scale_level(px.red, inten)));
            words.push_back(nibble_spread(scale_level(px.blue, inten)));
        end else begin
            // current-controlled: 5-bit level and rescaled intensity
            if (mode_reg == MODE_CURRENT) begin
                lev_prod = inten * 21'd7967;
                lev      = lev_prod[20:16] + 5'd1;
                rescaled = (inten * 13'd31) / lev;
                inten    = (rescaled > 13'd255) ? 8'hFF : rescaled[7:0];
                head     = {3'b111, lev};
            end
            if (px.first_pixel) begin
                words.push_back('0);
            end
            words.push_back({head, scale_level(px.blue, inten),
                             scale_level(px.green, inten), scale_level(px.red, inten)});
        end
        // zero tail, capped
        if (px.last_pixel) begin
            tails = (tail_reg > TAIL_CAP) ? TAIL_CAP : tail_reg;
            repeat (tails) words.push_back('0);
        end
        foreach (words[k]) begin
            pending_words.push_back('{words[k], k == words.size() - 1});
        end
    endfunction

    // offer one pixel, with random idle cycles ahead of it, until transferred
    task automatic offer_pixel(input t_pixel px);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // register write once every outstanding word has come out
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MODE:   mode_reg   = data[1:0];
            CFG_BRIGHT: bright_reg = data;
            CFG_TAIL:   tail_reg   = data[5:0];
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // brightness write keeps the input closed while the level is derived
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // output side: random back-pressure, plus one long hold when requested
    initial begin : out_side
        int hold_left;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) begin
                    @(negedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // compare each output transfer with the oldest queued word
    always @(posedge i_clk) begin : word_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word %h (last_word %b)", o_result.out_word,
                       o_result.last_word);
                word_errors++;
            end else begin
                want = pending_words.pop_front();
                if (o_result.out_word !== want.out_word) begin
                    $error("out_word: expected %h, got %h", want.out_word, o_result.out_word);
                    word_errors++;
                end
                if (o_result.last_word !== want.last_word) begin
                    $error("last_word: expected %b, got %b", want.last_word,
                           o_result.last_word);
                    word_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles == STALL_LIMIT) begin
                $error("no transfer for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_pixel      px;
        logic [31:0] typed_word;
        logic [7:0]  bright_pick;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        send_idle_pct = 15;
        recv_idle_pct = 53;
        foreach (DIR_TBL[k]) begin
            if (DIR_TBL[k].kind == ROW_CFG) begin
                write_reg(DIR_TBL[k].idx, DIR_TBL[k].data);
            end else begin
                if (DIR_TBL[k].n_typed == 2'd0) begin
                    encode_pixel_words(DIR_TBL[k].px);
                end else begin
                    for (int j = 0; j < DIR_TBL[k].n_typed; j++) begin
                        typed_word = (j == 0) ? DIR_TBL[k].w0 :
                                     (j == 1) ? DIR_TBL[k].w1 : DIR_TBL[k].w2;
                        pending_words.push_back('{typed_word, j == DIR_TBL[k].n_typed - 1});
                    end
                end
                offer_pixel(DIR_TBL[k].px);
            end
        end

        // random blocks, each under its own register setting
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            if (blk < 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 53;
            end else if (blk < 6) begin
                send_idle_pct = 53;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_MODE, {6'($urandom), 2'($urandom_range(3))});
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_TAIL, {2'($urandom_range(3)), 6'($urandom_range(56, 63))});
            end else begin
                write_reg(CFG_TAIL, {2'($urandom_range(3)), 6'($urandom_range(0, 12))});
            end
            case ($urandom_range(3))
                0:       bright_pick = 8'h00;
                1:       bright_pick = 8'hFF;
                default: bright_pick = 8'($urandom);
            endcase
            write_reg(CFG_BRIGHT, bright_pick);
            // long receiver hold while pixels keep coming
            if (blk == RAND_BLOCKS - 2) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                px.red         = 8'($urandom);
                px.green       = 8'($urandom);
                px.blue        = 8'($urandom);
                px.first_pixel = ($urandom_range(3) == 0);
                px.last_pixel  = ($urandom_range(7) == 0);
                encode_pixel_words(px);
                offer_pixel(px);
            end
        end

        // drain and settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d words never arrived", pending_words.size());
        end
        if (word_errors == 0 && pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
